// ===== rtl/pcsc_pkg.sv =====
// shared types, codes and constants of the png chunk stream classifier
`default_nettype none
package pcsc_pkg;

  // byte roles
  localparam logic [2:0] CLS_SIG      = 3'd0;
  localparam logic [2:0] CLS_LEN      = 3'd1;
  localparam logic [2:0] CLS_TYPE     = 3'd2;
  localparam logic [2:0] CLS_DATA     = 3'd3;
  localparam logic [2:0] CLS_CRC      = 3'd4;
  localparam logic [2:0] CLS_AFTER    = 3'd5;
  localparam logic [2:0] CLS_REJECTED = 3'd6;

  // parser phases
  localparam logic [2:0] PH_SIG  = 3'd0;
  localparam logic [2:0] PH_LEN  = 3'd1;
  localparam logic [2:0] PH_TYPE = 3'd2;
  localparam logic [2:0] PH_DATA = 3'd3;
  localparam logic [2:0] PH_CRC  = 3'd4;

  localparam logic [31:0] TYPE_IHDR  = 32'h4948_4452;
  localparam logic [31:0] TYPE_IEND  = 32'h4945_4E44;
  localparam int          IHDR_BYTES = 13;
  localparam int          SIG_BYTES  = 8;
  localparam int          OUT_BITS   = 176;

  typedef logic [7:0] byte_t;

  // png file signature
  localparam byte_t SIG_TABLE [SIG_BYTES] = '{
    8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A
  };

  typedef struct packed {
    logic [2:0]  byte_class;
    logic [31:0] chunk_length;
    logic [31:0] chunk_type;
    logic        header_valid;
    logic [31:0] image_width;
    logic [31:0] image_height;
    byte_t       sample_depth;
    byte_t       colour_kind;
    byte_t       compression_method;
    byte_t       filter_method;
    byte_t       interlace_method;
  } pcsc_result_t;

endpackage
`default_nettype wire

// ===== rtl/pcsc_parser.sv =====
// parser state and per-byte classification logic
`default_nettype none
module pcsc_parser
  import pcsc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         step,
  input  wire byte_t        data_byte,
  input  wire logic         file_start,
  output pcsc_result_t      result
);

  logic [2:0]  sig_index;
  logic [2:0]  phase;
  logic [31:0] part_counter;
  logic [31:0] length_reg;
  logic [31:0] type_reg;
  logic        header_flag;
  logic        rejected_flag;
  logic        ended_flag;
  byte_t       header_bytes [IHDR_BYTES];

  logic [2:0]  sig_index_cur, sig_index_next;
  logic [2:0]  phase_cur, phase_next;
  logic [31:0] part_counter_cur, part_counter_next, count_inc;
  logic [31:0] length_cur, length_next;
  logic [31:0] type_cur, type_next;
  logic        header_flag_cur, header_flag_next;
  logic        rejected_cur, rejected_next;
  logic        ended_cur, ended_next;
  logic [2:0]  cls;
  logic        hdr_we;
  logic [3:0]  hdr_pos;
  byte_t       hdr_view [IHDR_BYTES];

  always_comb begin
    // a file start byte sees freshly cleared state
    if (file_start) begin
      sig_index_cur    = '0;
      phase_cur        = PH_SIG;
      part_counter_cur = '0;
      length_cur       = '0;
      type_cur         = '0;
      header_flag_cur  = 1'b0;
      rejected_cur     = 1'b0;
      ended_cur        = 1'b0;
    end else begin
      sig_index_cur    = sig_index;
      phase_cur        = phase;
      part_counter_cur = part_counter;
      length_cur       = length_reg;
      type_cur         = type_reg;
      header_flag_cur  = header_flag;
      rejected_cur     = rejected_flag;
      ended_cur        = ended_flag;
    end

    sig_index_next    = sig_index_cur;
    phase_next        = phase_cur;
    part_counter_next = part_counter_cur;
    length_next       = length_cur;
    type_next         = type_cur;
    header_flag_next  = header_flag_cur;
    rejected_next     = rejected_cur;
    ended_next        = ended_cur;
    count_inc         = part_counter_cur + 32'd1;
    hdr_we            = 1'b0;
    hdr_pos           = part_counter_cur[3:0];
    cls               = CLS_REJECTED;

    priority if (rejected_cur) begin
      cls = CLS_REJECTED;
    end else if (ended_cur) begin
      cls = CLS_AFTER;
    end else begin
      unique case (phase_cur)
        PH_SIG: begin
          if (data_byte == SIG_TABLE[sig_index_cur]) begin
            cls            = CLS_SIG;
            sig_index_next = sig_index_cur + 3'd1;
            if (sig_index_cur == 3'(SIG_BYTES - 1)) begin
              phase_next        = PH_LEN;
              part_counter_next = '0;
            end
          end else begin
            cls           = CLS_REJECTED;
            rejected_next = 1'b1;
          end
        end
        PH_LEN: begin
          cls         = CLS_LEN;
          length_next = {length_cur[23:0], data_byte};
          if (count_inc >= 32'd4) begin
            part_counter_next = '0;
            phase_next        = PH_TYPE;
          end else begin
            part_counter_next = count_inc;
          end
        end
        PH_TYPE: begin
          cls       = CLS_TYPE;
          type_next = {type_cur[23:0], data_byte};
          if (count_inc >= 32'd4) begin
            part_counter_next = '0;
            // zero-length chunk goes straight to its crc
            phase_next = (length_cur == 32'd0) ? PH_CRC : PH_DATA;
          end else begin
            part_counter_next = count_inc;
          end
        end
        PH_DATA: begin
          cls = CLS_DATA;
          if (type_cur == TYPE_IHDR && length_cur >= 32'(IHDR_BYTES) &&
              part_counter_cur < 32'(IHDR_BYTES)) begin
            hdr_we = 1'b1;
            if (part_counter_cur == 32'(IHDR_BYTES - 1)) begin
              header_flag_next = 1'b1;
            end
          end
          if (count_inc >= length_cur) begin
            part_counter_next = '0;
            phase_next        = PH_CRC;
          end else begin
            part_counter_next = count_inc;
          end
        end
        PH_CRC: begin
          cls = CLS_CRC;
          if (count_inc >= 32'd4) begin
            part_counter_next = '0;
            if (type_cur == TYPE_IEND) begin
              ended_next = 1'b1;
            end else begin
              phase_next = PH_LEN;
            end
          end else begin
            part_counter_next = count_inc;
          end
        end
        default: begin
          cls           = CLS_REJECTED;
          rejected_next = 1'b1;
        end
      endcase
    end
  end

  // header bytes as they stand after this byte
  always_comb begin
    for (int i = 0; i < IHDR_BYTES; i++) begin
      hdr_view[i] = (hdr_we && hdr_pos == 4'(i)) ? data_byte : header_bytes[i];
    end
  end

  always_comb begin
    result.byte_class   = cls;
    result.chunk_length = length_next;
    result.chunk_type   = type_next;
    result.header_valid = header_flag_next;
    if (header_flag_next) begin
      result.image_width        = {hdr_view[0], hdr_view[1], hdr_view[2], hdr_view[3]};
      result.image_height       = {hdr_view[4], hdr_view[5], hdr_view[6], hdr_view[7]};
      result.sample_depth       = hdr_view[8];
      result.colour_kind        = hdr_view[9];
      result.compression_method = hdr_view[10];
      result.filter_method      = hdr_view[11];
      result.interlace_method   = hdr_view[12];
    end else begin
      result.image_width        = '0;
      result.image_height       = '0;
      result.sample_depth       = '0;
      result.colour_kind        = '0;
      result.compression_method = '0;
      result.filter_method      = '0;
      result.interlace_method   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sig_index     <= '0;
      phase         <= PH_SIG;
      part_counter  <= '0;
      length_reg    <= '0;
      type_reg      <= '0;
      header_flag   <= 1'b0;
      rejected_flag <= 1'b0;
      ended_flag    <= 1'b0;
    end else if (step) begin
      sig_index     <= sig_index_next;
      phase         <= phase_next;
      part_counter  <= part_counter_next;
      length_reg    <= length_next;
      type_reg      <= type_next;
      header_flag   <= header_flag_next;
      rejected_flag <= rejected_next;
      ended_flag    <= ended_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && hdr_we) begin
      header_bytes[hdr_pos] <= data_byte;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/png_chunk_stream_classifier.sv =====
// top level of the png chunk stream classifier
`default_nettype none
// Classifies a PNG file streamed in one byte per request and returns one result per byte:
// its role (signature, chunk length, chunk type, chunk data, chunk crc, after IEND or
// rejected), the current chunk's length and type, and the IHDR fields once an IHDR chunk
// of at least 13 data bytes has delivered its 13th byte. A request with tuser set starts a
// new file; the state after reset is that of a new file. A signature mismatch rejects that
// byte and the rest of the file. The block sustains one byte per clock cycle while the
// result side is not stalled; a result is presented once its byte has passed from the
// input register into the result register: the byte is held in an input register, the
// parser updates its state while the byte moves into the result register, and the result
// register holds a finished result while the next byte is already accepted.
module png_chunk_stream_classifier
  import pcsc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_axis_tvalid,
  output      logic                s_axis_tready,
  // [7:0] data_byte
  input  wire logic [7:0]          s_axis_tdata,
  // [0] file_start
  input  wire logic                s_axis_tuser,
  output      logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [2:0] byte_class, [34:3] chunk_length, [66:35] chunk_type, [67] header_valid,
  // [99:68] image_width, [131:100] image_height, [139:132] sample_depth,
  // [147:140] colour_kind, [155:148] compression_method, [163:156] filter_method,
  // [171:164] interlace_method, [175:172] zero
  output      logic [OUT_BITS-1:0] m_axis_tdata
);

  // input register
  logic         in_valid;
  byte_t        in_byte;
  logic         in_start;

  // parser advances when the held byte can move into the result register
  logic         advance;
  pcsc_result_t step_result;

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte  <= s_axis_tdata;
      in_start <= s_axis_tuser;
    end
  end

  pcsc_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .data_byte  (in_byte),
    .file_start (in_start),
    .result     (step_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= {4'b0000,
                       step_result.interlace_method,
                       step_result.filter_method,
                       step_result.compression_method,
                       step_result.colour_kind,
                       step_result.sample_depth,
                       step_result.image_height,
                       step_result.image_width,
                       step_result.header_valid,
                       step_result.chunk_type,
                       step_result.chunk_length,
                       step_result.byte_class};
    end
  end

`ifndef SYNTHESIS
  // a signature byte is only seen before any chunk field has been taken in
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[2:0] == CLS_SIG) |->
      (!m_axis_tdata[67] && m_axis_tdata[34:3] == 32'd0 && m_axis_tdata[66:35] == 32'd0))
    else $error("signature result carries chunk or header state");

  // rejection only happens in the signature, so no header can be valid
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[2:0] == CLS_REJECTED) |-> !m_axis_tdata[67])
    else $error("rejected result with header valid");

  // a byte that moves on always produces a result
  assert property (@(posedge clk) disable iff (rst)
    advance |=> m_axis_tvalid)
    else $error("result lost after parser step");

  // a held byte is not dropped while the result side stalls
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> (in_valid && $stable(in_byte) && $stable(in_start)))
    else $error("input register changed while stalled");
`endif

endmodule
`default_nettype wire
